FILE: rtl/core/qts_pkg.sv
// quoted token scanner: shared types, codes and constants
// used by every module of the scanner; depends on nothing else
package qts_pkg;

  // defaults for the top level parameters
  localparam int unsigned OffsetBitsDef = 16;
  localparam int unsigned DelimSlotsDef = 4;

  // widths fixed by the register map and the result fields
  localparam int unsigned DelimCharsW = 32;
  localparam int unsigned DelimCountW = 3;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned OutOffW     = 16;
  localparam int unsigned KindW       = 2;

  // depth of the queue between the front and back parts
  localparam int unsigned QueueDepth = 4;

  // character codes
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DELIM_CHARS = 2'd0,
    REG_DELIM_COUNT = 2'd1,
    REG_CONSUME     = 2'd2,
    REG_ESC_OFF     = 2'd3
  } cfg_idx_e;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // scan phase
  typedef enum logic [2:0] {
    PH_DONE  = 3'd0,
    PH_SKIP  = 3'd1,
    PH_UNQ   = 3'd2,
    PH_QUOTE = 3'd3,
    PH_ESC   = 3'd4
  } phase_e;

  // one queue entry: one result, or an escaped pair (backslash then the byte)
  typedef struct packed {
    logic               pair;
    kind_e              kind;
    logic [7:0]         data;
    logic [OutOffW-1:0] offset;
  } q_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/core/qts_queue.sv
// short queue of result entries between the front and back parts
// depends on qts_pkg
module qts_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qts_pkg::q_entry_t wr_entry_i,
  input  logic              pop_i,
  output qts_pkg::q_entry_t rd_entry_o,
  output qts_pkg::q_stat_t  stat_o
);

  localparam int unsigned PtrW = (qts_pkg::QueueDepth > 1) ? $clog2(qts_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(qts_pkg::QueueDepth + 1);

  qts_pkg::q_entry_t mem_q [qts_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(qts_pkg::QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rd_entry_o   = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(qts_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(qts_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

FILE: rtl/core/qts_front.sv
// front part: configuration registers, byte classification and scan phase
// depends on qts_pkg; produces entries for qts_queue
module qts_front #(
  parameter int unsigned OFFSET_BITS = qts_pkg::OffsetBitsDef,
  parameter int unsigned DELIM_SLOTS = qts_pkg::DelimSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  qts_pkg::cfg_idx_e             cfg_index_i,
  input  logic [qts_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  input  logic [7:0]                    in_ch_i,
  input  logic                          in_first_i,
  output logic                          in_ready_o,
  input  qts_pkg::q_stat_t              q_stat_i,
  output logic                          push_o,
  output qts_pkg::q_entry_t             entry_o
);

  localparam int unsigned DelimW = 8 * DELIM_SLOTS;
  localparam int unsigned WideW  = OFFSET_BITS + qts_pkg::OutOffW;

  // configuration registers
  logic [qts_pkg::DelimCharsW-1:0] delim_chars_q;
  logic [qts_pkg::DelimCountW-1:0] delim_count_q;
  logic                            consume_q;
  logic                            esc_off_q;

  // scan state
  qts_pkg::phase_e      phase_q, phase_d;
  logic                 dquote_q, dquote_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;

  qts_pkg::phase_e        eff_phase;
  logic                   eff_dquote;
  logic [OFFSET_BITS-1:0] eff_off, off_inc;
  logic [DelimW-1:0]      delim_ext;
  logic                   is_space, is_delim, is_quote, is_close, accept, emit;
  logic [7:0]             close_ch;
  logic [WideW-1:0]       wide_p, wide_inc;
  logic [qts_pkg::OutOffW-1:0] out_p, out_inc;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // a first flag restarts the scan at offset zero
  assign eff_phase  = in_first_i ? qts_pkg::PH_SKIP : phase_q;
  assign eff_dquote = in_first_i ? 1'b0 : dquote_q;
  assign eff_off    = in_first_i ? '0 : offset_q;
  assign off_inc    = (eff_off == {OFFSET_BITS{1'b1}}) ? eff_off : eff_off + 1'b1;

  // offsets clamped into the result field
  assign wide_p   = WideW'(eff_off);
  assign wide_inc = WideW'(off_inc);
  assign out_p    = (wide_p > WideW'({qts_pkg::OutOffW{1'b1}})) ?
                    {qts_pkg::OutOffW{1'b1}} : wide_p[qts_pkg::OutOffW-1:0];
  assign out_inc  = (wide_inc > WideW'({qts_pkg::OutOffW{1'b1}})) ?
                    {qts_pkg::OutOffW{1'b1}} : wide_inc[qts_pkg::OutOffW-1:0];

  // byte classes
  assign is_space = (in_ch_i == qts_pkg::ChSpace) ||
                    ((in_ch_i >= qts_pkg::ChTab) && (in_ch_i <= qts_pkg::ChCr));
  assign is_quote = (in_ch_i == qts_pkg::ChSquote) || (in_ch_i == qts_pkg::ChDquote);
  assign close_ch = eff_dquote ? qts_pkg::ChDquote : qts_pkg::ChSquote;
  assign is_close = (in_ch_i == close_ch);
  assign delim_ext = DelimW'(delim_chars_q);

  // delimiter slots in use, a zero slot never matches
  always_comb begin
    is_delim = 1'b0;
    for (int i = 0; i < DELIM_SLOTS; i++) begin
      if ((4'(i) < {1'b0, delim_count_q}) && (delim_ext[8*i +: 8] != qts_pkg::ChNul) &&
          (delim_ext[8*i +: 8] == in_ch_i)) begin
        is_delim = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    dquote_d = dquote_q;
    offset_d = offset_q;
    if (accept) begin
      phase_d  = eff_phase;
      dquote_d = eff_dquote;
      if (eff_phase != qts_pkg::PH_DONE) begin
        offset_d = off_inc;
      end
      case (eff_phase)
        qts_pkg::PH_SKIP, qts_pkg::PH_UNQ: begin
          if (eff_phase == qts_pkg::PH_SKIP && in_ch_i != qts_pkg::ChNul && is_space) begin
            phase_d = qts_pkg::PH_SKIP;
          end else if (eff_phase == qts_pkg::PH_SKIP && is_quote) begin
            phase_d  = qts_pkg::PH_QUOTE;
            dquote_d = (in_ch_i == qts_pkg::ChDquote);
          end else if (in_ch_i == qts_pkg::ChNul || is_space || is_delim) begin
            phase_d = qts_pkg::PH_DONE;
          end else begin
            phase_d = qts_pkg::PH_UNQ;
          end
        end
        qts_pkg::PH_QUOTE: begin
          if (in_ch_i == qts_pkg::ChNul) begin
            phase_d = qts_pkg::PH_DONE;
          end else if (!esc_off_q && in_ch_i == qts_pkg::ChBackslash) begin
            phase_d = qts_pkg::PH_ESC;
          end else if (is_close) begin
            phase_d = qts_pkg::PH_DONE;
          end
        end
        qts_pkg::PH_ESC: begin
          phase_d = (in_ch_i == qts_pkg::ChNul) ? qts_pkg::PH_DONE : qts_pkg::PH_QUOTE;
        end
        default: begin
          phase_d = qts_pkg::PH_DONE;
        end
      endcase
    end
  end

  // result entry for the byte
  always_comb begin
    emit          = 1'b0;
    entry_o.pair   = 1'b0;
    entry_o.kind   = qts_pkg::KIND_BYTE;
    entry_o.data   = '0;
    entry_o.offset = '0;
    case (eff_phase)
      qts_pkg::PH_SKIP, qts_pkg::PH_UNQ: begin
        if (eff_phase == qts_pkg::PH_SKIP &&
            ((in_ch_i != qts_pkg::ChNul && is_space) || is_quote)) begin
          emit = 1'b0;
        end else if (in_ch_i == qts_pkg::ChNul) begin
          emit           = 1'b1;
          entry_o.kind   = qts_pkg::KIND_DONE;
          entry_o.offset = out_p;
        end else if (is_space || is_delim) begin
          emit           = 1'b1;
          entry_o.kind   = qts_pkg::KIND_DONE;
          entry_o.offset = consume_q ? out_inc : out_p;
        end else begin
          emit         = 1'b1;
          entry_o.data = in_ch_i;
        end
      end
      qts_pkg::PH_QUOTE: begin
        if (in_ch_i == qts_pkg::ChNul) begin
          emit         = 1'b1;
          entry_o.kind = qts_pkg::KIND_ERROR;
        end else if (!esc_off_q && in_ch_i == qts_pkg::ChBackslash) begin
          emit = 1'b0;
        end else if (is_close) begin
          emit           = 1'b1;
          entry_o.kind   = qts_pkg::KIND_DONE;
          entry_o.offset = out_inc;
        end else begin
          emit         = 1'b1;
          entry_o.data = in_ch_i;
        end
      end
      qts_pkg::PH_ESC: begin
        emit = 1'b1;
        if (in_ch_i == qts_pkg::ChNul) begin
          entry_o.kind = qts_pkg::KIND_ERROR;
        end else begin
          entry_o.data = in_ch_i;
          entry_o.pair = !(in_ch_i == qts_pkg::ChBackslash || is_quote);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push_o = accept && emit;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= qts_pkg::PH_DONE;
      dquote_q <= 1'b0;
      offset_q <= '0;
    end else begin
      phase_q  <= phase_d;
      dquote_q <= dquote_d;
      offset_q <= offset_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_chars_q <= '0;
      delim_count_q <= '0;
      consume_q     <= 1'b0;
      esc_off_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        qts_pkg::REG_DELIM_CHARS: delim_chars_q <= cfg_data_i[qts_pkg::DelimCharsW-1:0];
        qts_pkg::REG_DELIM_COUNT: delim_count_q <= cfg_data_i[qts_pkg::DelimCountW-1:0];
        qts_pkg::REG_CONSUME:     consume_q     <= cfg_data_i[0];
        qts_pkg::REG_ESC_OFF:     esc_off_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/qts_back.sv
// back part: splits escaped pairs and holds the output register
// depends on qts_pkg; reads entries from qts_queue
module qts_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qts_pkg::q_entry_t        head_i,
  input  qts_pkg::q_stat_t         q_stat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output qts_pkg::kind_e           out_kind_o,
  output logic [7:0]               out_data_o,
  output logic [qts_pkg::OutOffW-1:0] out_offset_o,
  output logic                     out_last_o
);

  logic                         valid_q, valid_d;
  logic                         half_q, half_d;
  logic                         load;
  qts_pkg::kind_e               kind_q, kind_d;
  logic [7:0]                   data_q, data_d;
  logic [qts_pkg::OutOffW-1:0]  offset_q, offset_d;
  logic                         last_q, last_d;

  // output register is free or being emptied this cycle
  assign load = !valid_q || out_ready_i;

  // pick the next result from the queue head
  always_comb begin
    valid_d  = valid_q;
    half_d   = half_q;
    kind_d   = kind_q;
    data_d   = data_q;
    offset_d = offset_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        kind_d   = head_i.kind;
        offset_d = head_i.offset;
        if (head_i.pair && !half_q) begin
          // escaped pair: backslash first, entry stays
          data_d = qts_pkg::ChBackslash;
          last_d = 1'b0;
          half_d = 1'b1;
        end else begin
          data_d = head_i.data;
          last_d = 1'b1;
          half_d = 1'b0;
          pop_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    data_q   <= data_d;
    offset_q <= offset_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign out_kind_o   = kind_q;
  assign out_data_o   = data_q;
  assign out_offset_o = offset_q;
  assign out_last_o   = last_q;

endmodule

FILE: rtl/core/quoted_token_scanner.sv
// quoted token scanner top level: front part, result queue, back part
// depends on qts_pkg, qts_front, qts_queue and qts_back
//
// channel    direction  transaction
// s_axis     in         one string byte, tdata = ch, tuser = first
// m_axis     out        one result, tdata = byte_out/next_offset, tuser = kind, tlast = last
// cfg        in         one register write, index and data
//
// one byte is taken every cycle while the result queue has room; a byte is
// classified and its phase updated in the cycle it is accepted.
// results leave through a registered output, one per cycle while m_axis_tready is
// high; an escaped pair takes two output transfers, which the four-entry queue absorbs.
// a stalled output fills the queue and then holds s_axis_tready low.
// reset clears the scan to done; bytes are ignored until a first flag.
module quoted_token_scanner #(
  parameter int unsigned OFFSET_BITS = qts_pkg::OffsetBitsDef,
  parameter int unsigned DELIM_SLOTS = qts_pkg::DelimSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [qts_pkg::CfgDataW-1:0] cfg_data_i,
  // input bytes
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] ch
  input  logic                         s_axis_tuser,  // [0] first
  // results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // [7:0] byte_out, [23:8] next_offset
  output logic [qts_pkg::KindW-1:0]    m_axis_tuser,  // [1:0] kind
  output logic                         m_axis_tlast
);

  qts_pkg::q_entry_t wr_entry, head;
  qts_pkg::q_stat_t  q_stat;
  qts_pkg::kind_e    out_kind;
  logic              push, pop;
  logic [7:0]        out_data;
  logic [qts_pkg::OutOffW-1:0] out_offset;

  assign cfg_ready_o = 1'b1;

  // classification and scan state
  qts_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .DELIM_SLOTS (DELIM_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (qts_pkg::cfg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ch_i     (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .entry_o     (wr_entry)
  );

  // result queue
  qts_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wr_entry_i (wr_entry),
    .pop_i      (pop),
    .rd_entry_o (head),
    .stat_o     (q_stat)
  );

  // output stage
  qts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (out_kind),
    .out_data_o   (out_data),
    .out_offset_o (out_offset),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_offset, out_data};
  assign m_axis_tuser = out_kind;

  // no entry is pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_stat.full))
    else $error("result pushed into full queue");

  // the first half of a pair is a plain backslash byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      (m_axis_tuser == qts_pkg::KIND_BYTE) && (m_axis_tdata[7:0] == qts_pkg::ChBackslash))
    else $error("non-final result is not a backslash byte");

  // completion and error records always end the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != qts_pkg::KIND_BYTE) |-> m_axis_tlast)
    else $error("record without last flag");

  // the input stalls only on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !s_axis_tready |-> q_stat.full)
    else $error("input stalled with room in queue");

endmodule

FILE: tb/quoted_token_scanner_test.sv
// self-checking testbench for quoted_token_scanner: directed table, then random strings
// depends on qts_pkg and the quoted_token_scanner rtl; results checked against a predictor
`timescale 1ns / 100ps

module quoted_token_scanner_test;
  import qts_pkg::*;

  localparam int unsigned DirRows      = 27;
  localparam int unsigned Phases       = 6;
  localparam int unsigned LiveTarget   = 230;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldLen      = 300;
  localparam int unsigned WatchLimit   = 3000;

  // one input byte plus an optional hand-written expectation
  typedef struct packed {
    logic [7:0]  ch;
    logic        first;
    logic        fixed;
    logic [1:0]  n_fixed;
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] off;
  } stim_row_t;

  // one result as it leaves the block
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] off;
    logic        last;
  } token_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] ch
  logic                  s_axis_tuser = 1'b0; // [0] first
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;        // [7:0] byte_out, [23:8] next_offset
  logic [KindW-1:0]      m_axis_tuser;        // [1:0] kind
  logic                  m_axis_tlast;

  quoted_token_scanner u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scanner state and register copies kept by the predictor
  logic [31:0] dlm_chars = '0;
  logic [2:0]  dlm_count = '0;
  logic        consume_term = 1'b0;
  logic        esc_off = 1'b0;
  phase_e      scan_ph = PH_DONE;
  logic        quote_dbl = 1'b0;
  logic [15:0] scan_off = '0;

  token_res_t  token_q[$];
  stim_row_t   cur_item = '0;
  int unsigned err_cnt = 0;
  int unsigned live_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cnt = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  // directed table: ch, first, fixed, n_fixed, kind, byte, offset
  stim_row_t dir_tab [DirRows] = '{
    '{8'h61, 1'b0, 1'b1, 2'd0, KIND_BYTE,  8'h00, 16'h0000},  // ignored after reset
    '{8'h00, 1'b1, 1'b1, 2'd1, KIND_DONE,  8'h00, 16'h0000},  // empty string
    '{8'h20, 1'b1, 1'b1, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h09, 1'b0, 1'b1, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h0D, 1'b0, 1'b1, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h61, 1'b0, 1'b1, 2'd1, KIND_BYTE,  8'h61, 16'h0000},
    '{8'hFF, 1'b0, 1'b1, 2'd1, KIND_BYTE,  8'hFF, 16'h0000},
    '{8'h20, 1'b0, 1'b1, 2'd1, KIND_DONE,  8'h00, 16'h0005},
    '{8'h7A, 1'b0, 1'b1, 2'd0, KIND_BYTE,  8'h00, 16'h0000},  // after completion
    '{8'h22, 1'b1, 1'b1, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h27, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h5C, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h22, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h5C, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h6E, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},  // escaped pair
    '{8'h5C, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h5C, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h22, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h27, 1'b1, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h78, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b1, 2'd1, KIND_ERROR, 8'h00, 16'h0000},  // open quote at end
    '{8'h27, 1'b1, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h5C, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b1, 2'd1, KIND_ERROR, 8'h00, 16'h0000},  // backslash at end
    '{8'h09, 1'b1, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h27, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000},
    '{8'h27, 1'b0, 1'b0, 2'd0, KIND_BYTE,  8'h00, 16'h0000}   // empty quoted token
  };

  function automatic logic is_ws(input logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < DelimSlotsDef; i++) begin
      if (i < dlm_count && dlm_chars[8*i +: 8] != ChNul && dlm_chars[8*i +: 8] == c) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // byte of an unquoted token, or the byte that ends it
  function automatic token_res_t unquoted_char(input logic [7:0] c, input logic [15:0] p);
    token_res_t r;
    if (c == ChNul) begin
      r = '{KIND_DONE, 8'h00, p, 1'b0};
      scan_ph = PH_DONE;
    end else if (is_ws(c) || is_delim(c)) begin
      r = '{KIND_DONE, 8'h00, consume_term ? sat_inc(p) : p, 1'b0};
      scan_ph = PH_DONE;
    end else begin
      r = '{KIND_BYTE, c, 16'h0000, 1'b0};
      scan_ph = PH_UNQ;
    end
    return r;
  endfunction

  // advance the scan by one byte; gives up to two results
  function automatic void scan_byte(input logic [7:0] c, input logic first,
                                    output token_res_t r0, output token_res_t r1,
                                    output int n, output logic live);
    logic [7:0] close_q;
    r0 = '0;
    r1 = '0;
    n = 0;
    if (first) begin
      scan_ph = PH_SKIP;
      quote_dbl = 1'b0;
      scan_off = '0;
    end
    live = (scan_ph != PH_DONE);
    if (!live) return;
    close_q = quote_dbl ? ChDquote : ChSquote;
    case (scan_ph)
      PH_SKIP: begin
        if (c != ChNul && is_ws(c)) begin
          n = 0;
        end else if (c == ChSquote || c == ChDquote) begin
          quote_dbl = (c == ChDquote);
          scan_ph = PH_QUOTE;
        end else begin
          r0 = unquoted_char(c, scan_off);
          n = 1;
        end
      end
      PH_UNQ: begin
        r0 = unquoted_char(c, scan_off);
        n = 1;
      end
      PH_QUOTE: begin
        if (c == ChNul) begin
          r0 = '{KIND_ERROR, 8'h00, 16'h0000, 1'b0};
          scan_ph = PH_DONE;
          n = 1;
        end else if (!esc_off && c == ChBackslash) begin
          scan_ph = PH_ESC;
        end else if (c == close_q) begin
          r0 = '{KIND_DONE, 8'h00, sat_inc(scan_off), 1'b0};
          scan_ph = PH_DONE;
          n = 1;
        end else begin
          r0 = '{KIND_BYTE, c, 16'h0000, 1'b0};
          n = 1;
        end
      end
      default: begin
        if (c == ChNul) begin
          r0 = '{KIND_ERROR, 8'h00, 16'h0000, 1'b0};
          scan_ph = PH_DONE;
          n = 1;
        end else if (c == ChBackslash || c == ChSquote || c == ChDquote) begin
          r0 = '{KIND_BYTE, c, 16'h0000, 1'b0};
          scan_ph = PH_QUOTE;
          n = 1;
        end else begin
          r0 = '{KIND_BYTE, ChBackslash, 16'h0000, 1'b0};
          r1 = '{KIND_BYTE, c, 16'h0000, 1'b0};
          scan_ph = PH_QUOTE;
          n = 2;
        end
      end
    endcase
    scan_off = sat_inc(scan_off);
    if (n == 1) r0.last = 1'b1;
    if (n == 2) r1.last = 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // transaction monitor: check results, predict for accepted bytes
  always @(posedge clk_i) begin : monitor
    token_res_t got;
    token_res_t want;
    token_res_t p0;
    token_res_t p1;
    int pn;
    logic live;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{kind_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast};
      if (token_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h offset %0d",
                                  got.kind, got.data, got.off));
      end else begin
        want = token_q.pop_front();
        if (got.kind != want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.data != want.data)
          report_mismatch($sformatf("byte %02h, want %02h", got.data, want.data));
        if (got.off != want.off)
          report_mismatch($sformatf("next offset %0d, want %0d", got.off, want.off));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      scan_byte(cur_item.ch, cur_item.first, p0, p1, pn, live);
      if (live) live_cnt++;
      if (cur_item.fixed) begin
        if (cur_item.n_fixed != 0)
          token_q.push_back('{cur_item.kind, cur_item.data, cur_item.off, 1'b1});
      end else begin
        if (pn > 0) token_q.push_back(p0);
        if (pn > 1) token_q.push_back(p1);
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HoldLen) hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // offer one byte, with random gaps in front of it
  task automatic send_row(input stim_row_t it);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.ch;
    s_axis_tuser  <= it.first;
    cur_item      <= it;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] c, input logic first);
    send_row('{c, first, 1'b0, 2'd0, KIND_BYTE, 8'h00, 16'h0000});
  endtask

  // wait until every result is in and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all four registers back to back
  task automatic load_config(input logic [31:0] dc, input logic [2:0] cnt,
                             input logic cons, input logic eoff);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      case (i)
        0: begin cfg_index_i <= REG_DELIM_CHARS; cfg_data_i <= dc; end
        1: begin cfg_index_i <= REG_DELIM_COUNT; cfg_data_i <= 32'(cnt); end
        2: begin cfg_index_i <= REG_CONSUME;     cfg_data_i <= 32'(cons); end
        default: begin cfg_index_i <= REG_ESC_OFF; cfg_data_i <= 32'(eoff); end
      endcase
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    dlm_chars    = dc;
    dlm_count    = cnt;
    consume_term = cons;
    esc_off      = eoff;
  endtask

  function automatic logic [7:0] ws_char();
    return ($urandom_range(5) == 0) ? ChSpace : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] delim_char();
    return dlm_chars[8*$urandom_range(3) +: 8];
  endfunction

  // one string: mostly well-formed tokens with random content, some noise
  task automatic send_string();
    logic [7:0] str_q[$];
    logic [7:0] q;
    logic [7:0] oq;
    int unsigned sel;
    int unsigned r;
    sel = $urandom_range(99);
    repeat ($urandom_range(2)) str_q.push_back(ws_char());
    if (sel < 45) begin
      q  = $urandom_range(1) ? ChDquote : ChSquote;
      oq = (q == ChDquote) ? ChSquote : ChDquote;
      str_q.push_back(q);
      repeat ($urandom_range(8)) begin
        r = $urandom_range(99);
        if (r < 15) begin
          str_q.push_back(ChBackslash);
          case ($urandom_range(3))
            0: str_q.push_back(ChBackslash);
            1: str_q.push_back(ChSquote);
            2: str_q.push_back(ChDquote);
            default: str_q.push_back(8'($urandom_range(1, 255)));
          endcase
        end else if (r < 25) begin
          str_q.push_back(oq);
        end else if (r < 35) begin
          str_q.push_back($urandom_range(1) ? ws_char() : delim_char());
        end else begin
          str_q.push_back(8'($urandom_range(1, 255)));
        end
      end
      r = $urandom_range(99);
      if (r < 80) begin
        str_q.push_back(q);
      end else if (r < 90) begin
        str_q.push_back(ChNul);
      end else begin
        str_q.push_back(ChBackslash);
        str_q.push_back(ChNul);
      end
    end else if (sel < 85) begin
      repeat ($urandom_range(6)) str_q.push_back(8'($urandom_range(1, 255)));
      r = $urandom_range(99);
      if (r < 40) str_q.push_back(ws_char());
      else if (r < 75) str_q.push_back(delim_char());
      else str_q.push_back(ChNul);
    end else begin
      // noise: raw bytes, first flag now and then
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      return;
    end
    // trailing bytes after the end are ignored
    repeat ($urandom_range(2)) str_q.push_back(8'($urandom_range(255)));
    foreach (str_q[i]) send_byte(str_q[i], i == 0);
  endtask

  // main sequence
  initial begin
    int unsigned goal;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    for (int ph = 0; ph < Phases; ph++) begin
      src_idle_pct  = (ph < 2) ? 9 : (ph < 4) ? 51 : 0;
      sink_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 9 : 0;
      case (ph)
        0: load_config(32'h0000_0000, 3'd0, 1'b0, 1'b0);
        1: load_config(32'h7C3A_3B2C, 3'd4, 1'b1, 1'b0);
        2: load_config(32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1);
        3: load_config($urandom, 3'd2, 1'b0, 1'b1);
        4: load_config(32'h2D00_3A00, 3'd3, 1'b1, 1'b0);
        default: load_config($urandom, 3'd4, 1'b0, 1'b0);
      endcase
      if (ph == 0) begin
        foreach (dir_tab[i]) send_row(dir_tab[i]);
        settle();
      end
      if (ph == 1) begin
        // receiver holds off while strings keep coming
        hold_req <= 1'b1;
      end
      goal = live_cnt + LiveTarget;
      while (live_cnt < goal) send_string();
      settle();
    end
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
